@@ rtl/core/alrs_pkg.sv @@
package alrs_pkg;

    localparam int MAX_POINTS  = 64;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int IDX_W       = 6;
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 32;
    localparam int CUM_W       = 40;
    localparam int POS_W       = 24;
    localparam int QUOT_W      = POS_W + 1;
    localparam int SQ_W        = 64;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int PROD_W      = COORD_W + 1 + POS_W;
    localparam int DIV_CNT_W   = $clog2(POS_W + 1);
    localparam int SQRT_CNT_W  = $clog2(ROOT_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        MODE_TABLE = 1'b0,
        MODE_POINT = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        CMD_TABLE_ENTRY,
        CMD_TABLE_CLOSE,
        CMD_POINT,
        CMD_LINE_CLOSE
    } cmd_kind_t;

    typedef struct packed {
        mode_t               mode;
        logic [STEP_W-1:0]   step_len;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  z_coord;
        logic                last;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]    point_index;
        logic [COORD_W-1:0]  x_out;
        logic [COORD_W-1:0]  z_out;
        logic                last_out;
        logic                degenerate;
    } out_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [STEP_W-1:0]   step_len;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  z_coord;
    } cmd_t;

    typedef struct packed {
        logic                start;
        logic [CUM_W-1:0]    num;
        logic [CUM_W-1:0]    den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } div_rsp_t;

    typedef struct packed {
        logic                start;
        logic [SQ_W-1:0]     val;
    } sqrt_req_t;

    typedef struct packed {
        logic                done;
        logic [ROOT_W-1:0]   root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TGT_RD,
        ST_TGT_DIV,
        ST_TGT_WAIT,
        ST_CH_RD,
        ST_CH_LOAD,
        ST_CH_SQA,
        ST_CH_SQB,
        ST_CH_WAIT,
        ST_U_RD,
        ST_U_DIV,
        ST_U_WAIT,
        ST_E_BEGIN,
        ST_E_PLD,
        ST_E_TLD,
        ST_E_URD,
        ST_E_ULD,
        ST_E_RDIV,
        ST_E_RWAIT,
        ST_E_P0,
        ST_E_P1,
        ST_E_PD,
        ST_E_MX,
        ST_E_MZ,
        ST_E_FZ,
        ST_E_OUT
    } back_state_t;

endpackage

@@ rtl/core/alrs_ram.sv @@
module alrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ rtl/core/alrs_div.sv @@
module alrs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  alrs_pkg::div_req_t req,
    output alrs_pkg::div_rsp_t rsp
);
    import alrs_pkg::*;

    logic [CUM_W:0]         rem_reg;
    logic [CUM_W-1:0]       den_reg;
    logic [QUOT_W-1:0]      quot_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [CUM_W:0]         rem_sh;
    logic                   fits;

    assign rem_sh = {rem_reg[CUM_W-1:0], 1'b0};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(POS_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.den;
            if (req.num >= req.den) begin
                quot_reg <= QUOT_W'(1);
                rem_reg  <= {1'b0, req.num - req.den};
            end else begin
                quot_reg <= '0;
                rem_reg  <= {1'b0, req.num};
            end
        end else if (busy_reg) begin
            rem_reg  <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ rtl/core/alrs_sqrt.sv @@
module alrs_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  alrs_pkg::sqrt_req_t req,
    output alrs_pkg::sqrt_rsp_t rsp
);
    import alrs_pkg::*;

    logic [SQ_W-1:0]        val_reg;
    logic [SQ_W-1:0]        root_reg;
    logic [SQ_W-1:0]        bit_reg;
    logic [SQRT_CNT_W-1:0]  cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [SQ_W:0]          trial;
    logic                   ge;

    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign ge    = {1'b0, val_reg} >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // two radicand bits per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            val_reg  <= req.val;
            root_reg <= '0;
            bit_reg  <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (ge) begin
                val_reg  <= val_reg - trial[SQ_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg[ROOT_W-1:0];

endmodule

@@ rtl/core/alrs_front.sv @@
module alrs_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  alrs_pkg::in_t  s_payload,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output alrs_pkg::cmd_t cmd
);
    import alrs_pkg::*;

    cmd_t               q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    cmd_t               item;
    logic               push;
    logic               pop;

    always_comb begin
        item.step_len = s_payload.step_len;
        item.x_coord  = s_payload.x_coord;
        item.z_coord  = s_payload.z_coord;
        if (s_payload.mode == MODE_TABLE) begin
            item.kind = s_payload.last ? CMD_TABLE_CLOSE : CMD_TABLE_ENTRY;
        end else begin
            item.kind = s_payload.last ? CMD_LINE_CLOSE : CMD_POINT;
        end
    end

    assign s_ready   = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign cmd_valid = count_reg != '0;
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

@@ rtl/core/alrs_back.sv @@
module alrs_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  alrs_pkg::cmd_t cmd,
    output logic           m_valid,
    input  logic           m_ready,
    output alrs_pkg::out_t m_payload
);
    import alrs_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;

    logic [CNT_W-1:0]    spc_cnt_reg;
    logic [CUM_W-1:0]    tot_reg;
    logic                table_done_reg;
    logic [CNT_W-1:0]    pcnt_reg;
    logic [CNT_W-1:0]    n_reg;
    logic                degen_reg;
    logic [CNT_W-1:0]    k_reg;
    logic [COORD_W-1:0]  prev_x_reg;
    logic [COORD_W-1:0]  prev_z_reg;
    logic [COORD_W-1:0]  a_reg;
    logic [COORD_W-1:0]  b_reg;
    logic                sh_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [CUM_W-1:0]    cum_reg;
    logic [ADDR_W-1:0]   seg_reg;
    logic [QUOT_W-1:0]   useg_reg;
    logic [QUOT_W-1:0]   unext_reg;
    logic [POS_W-1:0]    r_reg;
    logic [POS_W-1:0]    ratio_reg;
    logic [COORD_W-1:0]  p0x_reg;
    logic [COORD_W-1:0]  p0z_reg;
    logic [COORD_W:0]    magx_reg;
    logic [COORD_W:0]    magz_reg;
    logic                negx_reg;
    logic                negz_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [COORD_W-1:0]  xo_reg;
    logic [COORD_W-1:0]  zo_reg;
    logic                m_valid_reg;
    out_t                m_payload_reg;

    logic                spc_we;
    logic [ADDR_W-1:0]   spc_waddr;
    logic [CUM_W-1:0]    spc_wdata;
    logic [ADDR_W-1:0]   spc_raddr;
    logic [CUM_W-1:0]    spc_rdata;
    logic                tgt_we;
    logic [ADDR_W-1:0]   tgt_waddr;
    logic [POS_W-1:0]    tgt_wdata;
    logic [ADDR_W-1:0]   tgt_raddr;
    logic [POS_W-1:0]    tgt_rdata;
    logic                pt_we;
    logic [ADDR_W-1:0]   pt_waddr;
    logic [ADDR_W-1:0]   pt_raddr;
    logic [COORD_W-1:0]  x_rdata;
    logic [COORD_W-1:0]  z_rdata;
    logic                cum_we;
    logic [ADDR_W-1:0]   cum_waddr;
    logic [CUM_W-1:0]    cum_wdata;
    logic [ADDR_W-1:0]   cum_raddr;
    logic [CUM_W-1:0]    cum_rdata;
    logic                u_we;
    logic [ADDR_W-1:0]   u_waddr;
    logic [ADDR_W-1:0]   u_raddr;
    logic [QUOT_W-1:0]   u_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    sqrt_req_t           sqrt_req;
    sqrt_rsp_t           sqrt_rsp;
    logic                out_load;

    logic [CNT_W-1:0]    spc_base;
    logic [CUM_W-1:0]    tot_base;
    logic                spc_room;
    logic [CUM_W-1:0]    tot_sum;
    logic [CNT_W-1:0]    spc_new;
    logic [CUM_W-1:0]    tot_new;
    logic                pnt_room;
    logic [CNT_W-1:0]    pnew;
    logic                degen0;
    logic [ADDR_W-1:0]   kx;
    logic [CNT_W-1:0]    k_inc;
    logic                last_k;
    logic                interior;
    logic [ADDR_W-1:0]   seg_inc;
    logic [COORD_W:0]    dx;
    logic [COORD_W:0]    dz;
    logic [COORD_W:0]    ax;
    logic [COORD_W:0]    az;
    logic                chord_big;
    logic [COORD_W:0]    chord;
    logic [CUM_W-1:0]    cum_new;
    logic [COORD_W:0]    dpx;
    logic [COORD_W:0]    dpz;
    logic [PROD_W-1:0]   prod_rnd;
    logic [COORD_W-1:0]  rnd;
    logic [POS_W:0]      tgt_sat;

    alrs_ram #(.WIDTH(CUM_W), .DEPTH(MAX_POINTS)) u_spc_ram (
        .aclk(aclk), .we(spc_we), .waddr(spc_waddr), .wdata(spc_wdata),
        .raddr(spc_raddr), .rdata(spc_rdata)
    );

    alrs_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_tgt_ram (
        .aclk(aclk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .raddr(tgt_raddr), .rdata(tgt_rdata)
    );

    alrs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
        .aclk(aclk), .we(pt_we), .waddr(pt_waddr), .wdata(cmd.x_coord),
        .raddr(pt_raddr), .rdata(x_rdata)
    );

    alrs_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_z_ram (
        .aclk(aclk), .we(pt_we), .waddr(pt_waddr), .wdata(cmd.z_coord),
        .raddr(pt_raddr), .rdata(z_rdata)
    );

    alrs_ram #(.WIDTH(CUM_W), .DEPTH(MAX_POINTS)) u_cum_ram (
        .aclk(aclk), .we(cum_we), .waddr(cum_waddr), .wdata(cum_wdata),
        .raddr(cum_raddr), .rdata(cum_rdata)
    );

    alrs_ram #(.WIDTH(QUOT_W), .DEPTH(MAX_POINTS)) u_pos_ram (
        .aclk(aclk), .we(u_we), .waddr(u_waddr), .wdata(div_rsp.quot),
        .raddr(u_raddr), .rdata(u_rdata)
    );

    alrs_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp)
    );

    alrs_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .req(sqrt_req), .rsp(sqrt_rsp)
    );

    // helper datapath
    always_comb begin
        spc_base  = table_done_reg ? '0 : spc_cnt_reg;
        tot_base  = table_done_reg ? '0 : tot_reg;
        spc_room  = spc_base < CNT_W'(MAX_POINTS - 1);
        tot_sum   = tot_base + CUM_W'(cmd.step_len);
        spc_new   = spc_room ? spc_base + 1'b1 : spc_base;
        tot_new   = spc_room ? tot_sum : tot_base;
        pnt_room  = pcnt_reg < CNT_W'(MAX_POINTS);
        pnew      = pnt_room ? pcnt_reg + 1'b1 : pcnt_reg;
        degen0    = !table_done_reg || (spc_cnt_reg != pnew - 1'b1) ||
                    (spc_cnt_reg == '0) || (tot_reg == '0);
        kx        = k_reg[ADDR_W-1:0];
        k_inc     = k_reg + 1'b1;
        last_k    = k_inc == n_reg;
        interior  = !degen_reg && (k_reg != '0) && !last_k;
        seg_inc   = seg_reg + 1'b1;

        dx        = {x_rdata[COORD_W-1], x_rdata} - {prev_x_reg[COORD_W-1], prev_x_reg};
        dz        = {z_rdata[COORD_W-1], z_rdata} - {prev_z_reg[COORD_W-1], prev_z_reg};
        ax        = dx[COORD_W] ? -dx : dx;
        az        = dz[COORD_W] ? -dz : dz;
        chord_big = (ax[COORD_W:COORD_W-1] != '0) || (az[COORD_W:COORD_W-1] != '0);
        chord     = sh_reg ? {sqrt_rsp.root, 1'b0} : {1'b0, sqrt_rsp.root};
        cum_new   = cum_reg + CUM_W'(chord);

        dpx       = {x_rdata[COORD_W-1], x_rdata} - {p0x_reg[COORD_W-1], p0x_reg};
        dpz       = {z_rdata[COORD_W-1], z_rdata} - {p0z_reg[COORD_W-1], p0z_reg};
        prod_rnd  = prod_reg + PROD_W'(1 << (POS_W - 1));
        rnd       = prod_rnd[POS_W +: COORD_W];

        tgt_sat   = div_rsp.quot[POS_W] ? {1'b0, {POS_W{1'b1}}} : div_rsp.quot;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_TABLE_CLOSE: state_next = (spc_new == '0) ? ST_IDLE : ST_TGT_RD;
                        CMD_LINE_CLOSE:  state_next = degen0 ? ST_E_BEGIN : ST_CH_RD;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TGT_RD:   state_next = ST_TGT_DIV;
            ST_TGT_DIV:  state_next = ST_TGT_WAIT;
            ST_TGT_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (k_reg == spc_cnt_reg) ? ST_IDLE : ST_TGT_RD;
                end
            end
            ST_CH_RD:    state_next = ST_CH_LOAD;
            ST_CH_LOAD:  state_next = (k_reg == '0) ? ST_CH_RD : ST_CH_SQA;
            ST_CH_SQA:   state_next = ST_CH_SQB;
            ST_CH_SQB:   state_next = ST_CH_WAIT;
            ST_CH_WAIT: begin
                if (sqrt_rsp.done) begin
                    if (!last_k) begin
                        state_next = ST_CH_RD;
                    end else begin
                        state_next = (cum_new == '0) ? ST_E_BEGIN : ST_U_RD;
                    end
                end
            end
            ST_U_RD:     state_next = ST_U_DIV;
            ST_U_DIV:    state_next = ST_U_WAIT;
            ST_U_WAIT: begin
                if (div_rsp.done) begin
                    state_next = last_k ? ST_E_BEGIN : ST_U_RD;
                end
            end
            ST_E_BEGIN:  state_next = interior ? ST_E_TLD : ST_E_PLD;
            ST_E_PLD:    state_next = ST_E_OUT;
            ST_E_TLD:    state_next = ST_E_URD;
            ST_E_URD:    state_next = ST_E_ULD;
            ST_E_ULD:    state_next = (u_rdata <= {1'b0, r_reg}) ? ST_E_URD : ST_E_RDIV;
            ST_E_RDIV:   state_next = ST_E_RWAIT;
            ST_E_RWAIT:  state_next = div_rsp.done ? ST_E_P0 : ST_E_RWAIT;
            ST_E_P0:     state_next = ST_E_P1;
            ST_E_P1:     state_next = ST_E_PD;
            ST_E_PD:     state_next = ST_E_MX;
            ST_E_MX:     state_next = ST_E_MZ;
            ST_E_MZ:     state_next = ST_E_FZ;
            ST_E_FZ:     state_next = ST_E_OUT;
            ST_E_OUT: begin
                if (out_load) begin
                    state_next = last_k ? ST_IDLE : ST_E_BEGIN;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        cmd_ready      = state_reg == ST_IDLE;
        spc_we         = 1'b0;
        spc_waddr      = spc_base[ADDR_W-1:0];
        spc_wdata      = tot_sum;
        spc_raddr      = kx - 1'b1;
        tgt_we         = 1'b0;
        tgt_waddr      = kx;
        tgt_wdata      = tgt_sat[POS_W-1:0];
        tgt_raddr      = kx;
        pt_we          = 1'b0;
        pt_waddr       = pcnt_reg[ADDR_W-1:0];
        pt_raddr       = kx;
        cum_we         = 1'b0;
        cum_waddr      = kx;
        cum_wdata      = cum_new;
        cum_raddr      = kx;
        u_we           = 1'b0;
        u_waddr        = kx;
        u_raddr        = seg_inc;
        div_req.start  = 1'b0;
        div_req.num    = spc_rdata;
        div_req.den    = tot_reg;
        sqrt_req.start = 1'b0;
        sqrt_req.val   = sq_reg + b_reg * b_reg;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_TABLE_ENTRY, CMD_TABLE_CLOSE: spc_we = spc_room;
                        CMD_POINT, CMD_LINE_CLOSE:        pt_we  = pnt_room;
                        default: ;
                    endcase
                end
            end
            ST_TGT_DIV:  div_req.start = 1'b1;
            ST_TGT_WAIT: tgt_we = div_rsp.done;
            ST_CH_LOAD: begin
                if (k_reg == '0) begin
                    cum_we    = 1'b1;
                    cum_wdata = '0;
                end
            end
            ST_CH_SQB:   sqrt_req.start = 1'b1;
            ST_CH_WAIT:  cum_we = sqrt_rsp.done;
            ST_U_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = cum_rdata;
                div_req.den   = cum_reg;
            end
            ST_U_WAIT:   u_we = div_rsp.done;
            ST_E_RDIV: begin
                div_req.start = 1'b1;
                div_req.num   = CUM_W'({1'b0, r_reg} - useg_reg);
                div_req.den   = CUM_W'(unext_reg - useg_reg);
            end
            ST_E_P0:     pt_raddr = seg_reg;
            ST_E_P1:     pt_raddr = seg_inc;
            ST_E_OUT:    out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            spc_cnt_reg    <= '0;
            table_done_reg <= 1'b0;
            pcnt_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && cmd_valid) begin
                case (cmd.kind)
                    CMD_TABLE_ENTRY: begin
                        spc_cnt_reg    <= spc_new;
                        table_done_reg <= 1'b0;
                    end
                    CMD_TABLE_CLOSE: begin
                        spc_cnt_reg    <= spc_new;
                        table_done_reg <= spc_new == '0;
                    end
                    CMD_POINT:      pcnt_reg <= pnew;
                    CMD_LINE_CLOSE: pcnt_reg <= '0;
                    default: ;
                endcase
            end
            if (state_reg == ST_TGT_WAIT && div_rsp.done && k_reg == spc_cnt_reg) begin
                table_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    tot_reg  <= (cmd.kind == CMD_TABLE_ENTRY || cmd.kind == CMD_TABLE_CLOSE)
                                ? tot_new : tot_reg;
                    k_reg    <= (cmd.kind == CMD_LINE_CLOSE) ? '0 : CNT_W'(1);
                    n_reg    <= pnew;
                    degen_reg <= degen0;
                    cum_reg  <= '0;
                    seg_reg  <= '0;
                    useg_reg <= '0;
                end
            end
            ST_TGT_WAIT: begin
                if (div_rsp.done) begin
                    k_reg <= k_inc;
                end
            end
            ST_CH_LOAD: begin
                prev_x_reg <= x_rdata;
                prev_z_reg <= z_rdata;
                a_reg      <= chord_big ? ax[COORD_W:1] : ax[COORD_W-1:0];
                b_reg      <= chord_big ? az[COORD_W:1] : az[COORD_W-1:0];
                sh_reg     <= chord_big;
                if (k_reg == '0) begin
                    k_reg <= k_inc;
                end
            end
            ST_CH_SQA:   sq_reg <= a_reg * a_reg;
            ST_CH_WAIT: begin
                if (sqrt_rsp.done) begin
                    cum_reg <= cum_new;
                    k_reg   <= last_k ? '0 : k_inc;
                    if (last_k && cum_new == '0) begin
                        degen_reg <= 1'b1;
                    end
                end
            end
            ST_U_WAIT: begin
                if (div_rsp.done) begin
                    k_reg <= last_k ? '0 : k_inc;
                end
            end
            ST_E_PLD: begin
                xo_reg <= x_rdata;
                zo_reg <= z_rdata;
            end
            ST_E_TLD:    r_reg <= tgt_rdata;
            ST_E_ULD: begin
                if (u_rdata <= {1'b0, r_reg}) begin
                    useg_reg <= u_rdata;
                    seg_reg  <= seg_inc;
                end else begin
                    unext_reg <= u_rdata;
                end
            end
            ST_E_RWAIT: begin
                if (div_rsp.done) begin
                    ratio_reg <= div_rsp.quot[POS_W-1:0];
                end
            end
            ST_E_PD: begin
                p0x_reg  <= p0x_reg;
                negx_reg <= dpx[COORD_W];
                negz_reg <= dpz[COORD_W];
                magx_reg <= dpx[COORD_W] ? -dpx : dpx;
                magz_reg <= dpz[COORD_W] ? -dpz : dpz;
            end
            ST_E_P1: begin
                p0x_reg <= x_rdata;
                p0z_reg <= z_rdata;
            end
            ST_E_MX:     prod_reg <= magx_reg * ratio_reg;
            ST_E_MZ: begin
                xo_reg   <= negx_reg ? p0x_reg - rnd : p0x_reg + rnd;
                prod_reg <= magz_reg * ratio_reg;
            end
            ST_E_FZ:     zo_reg <= negz_reg ? p0z_reg - rnd : p0z_reg + rnd;
            ST_E_OUT: begin
                if (out_load) begin
                    m_payload_reg.point_index <= IDX_W'(k_reg);
                    m_payload_reg.x_out       <= xo_reg;
                    m_payload_reg.z_out       <= zo_reg;
                    m_payload_reg.last_out    <= last_k;
                    m_payload_reg.degenerate  <= degen_reg;
                    k_reg                     <= k_inc;
                end
            end
            default: ;
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

@@ rtl/core/arc_length_curve_resampler.sv @@
// sequence: a table entry or line point that is not last waits in the front queue until the
// idle back end takes it; closing a table runs one division per entry on the one shared
// 24-step divider; closing a line loads the first point, then runs a 32-step square root per
// chord, a division per normalized position, and a search and a division per interior point
// throughput: one item per cycle between closes; a 2-entry queue buffers the input
// reset: synchronous active-low aresetn clears counts, flags and handshakes, not memories
module arc_length_curve_resampler (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  alrs_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output alrs_pkg::out_t m_payload
);
    import alrs_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    alrs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    alrs_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

endmodule
